// ----- sv/rans_enc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the interleaved rANS encoder.
// No dependencies; every other file of the block imports this package.
package rans_enc_pkg;

   localparam int LANES       = 64;
   localparam int SYMBOLS     = 256;
   localparam int LANE_W      = $clog2(LANES);
   localparam int SYM_W       = $clog2(SYMBOLS);
   localparam int FREQ_W      = 15;
   localparam int STATE_W     = 32;
   localparam int WORD_W      = 16;
   localparam int PB_W        = 4;
   localparam int DIV_STEPS   = STATE_W;
   localparam int CNT_W       = $clog2(DIV_STEPS);
   localparam int LIMIT_W     = STATE_W + 6;

   localparam logic [STATE_W-1:0] LOWER_BOUND = STATE_W'(65536);
   localparam logic [PB_W-1:0]    PB_MIN      = PB_W'(10);
   localparam logic [PB_W-1:0]    PB_MAX      = PB_W'(15);
   localparam logic [PB_W-1:0]    PB_RESET    = PB_W'(15);

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_ENCODE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_RESET  = 2'd3
   } kind_type;

   typedef struct packed {
      logic capture;
      logic read;
      logic eval;
      logic div_step;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic out_free;
   } dp_status_type;

   function automatic logic [PB_W-1:0] clamp_prob_bits(input logic [PB_W-1:0] pb);
      logic [PB_W-1:0] r;
      r = pb;
      if (pb < PB_MIN) begin
         r = PB_MIN;
      end else if (pb > PB_MAX) begin
         r = PB_MAX;
      end
      return r;
   endfunction

endpackage

// ----- sv/rans_enc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the rANS encoder: sequences capture, table reads,
// evaluation, the iterative division and result write-back. Uses rans_enc_pkg.
module rans_enc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  rans_enc_pkg::dp_status_type status,
   output rans_enc_pkg::ctrl_cmd_type  cmd
);
   import rans_enc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_READ   = 5'b00010,
      ST_EVAL   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            cnt_in   = '0;
            state_in = status.need_div ? ST_DIVIDE : ST_FINISH;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ----- sv/rans_enc_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the rANS encoder: lane state memory, symbol tables, the radix-2
// divider, state update and the result register. Uses rans_enc_pkg.
module rans_enc_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  rans_enc_pkg::ctrl_cmd_type  cmd,
   output rans_enc_pkg::dp_status_type status,
   input  logic                        csr_write_enable,
   input  logic [rans_enc_pkg::PB_W-1:0]    csr_write_data,
   input  logic [1:0]                       req_kind,
   input  logic [rans_enc_pkg::LANE_W-1:0]  req_lane,
   input  logic [rans_enc_pkg::SYM_W-1:0]   req_symbol,
   input  logic [rans_enc_pkg::FREQ_W-1:0]  req_frequency,
   input  logic [rans_enc_pkg::FREQ_W-1:0]  req_cumulative,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_word_valid,
   output logic [rans_enc_pkg::WORD_W-1:0]  rsp_out_word,
   output logic [rans_enc_pkg::STATE_W-1:0] rsp_state_value,
   output logic                             rsp_bad_symbol
);
   import rans_enc_pkg::*;

   logic [STATE_W-1:0] lane_mem [LANES];
   logic [FREQ_W-1:0]  freq_mem [SYMBOLS];
   logic [FREQ_W-1:0]  cum_mem  [SYMBOLS];
   logic [LANES-1:0]   lane_vld_ff;
   logic [SYMBOLS-1:0] tab_vld_ff;

   logic [PB_W-1:0]    prob_bits_ff;

   kind_type           kind_ff;
   logic [LANE_W-1:0]  lane_ff;
   logic [SYM_W-1:0]   sym_ff;
   logic [FREQ_W-1:0]  freq_ff;
   logic [FREQ_W-1:0]  cum_ff;

   logic [STATE_W-1:0] lane_q_ff;
   logic               lane_qv_ff;
   logic [FREQ_W-1:0]  freq_q_ff;
   logic [FREQ_W-1:0]  cum_q_ff;
   logic               tab_qv_ff;

   logic [STATE_W-1:0] quo_ff, quo_in;
   logic [FREQ_W-1:0]  rem_ff, rem_in;
   logic               wv_ff;
   logic [WORD_W-1:0]  word_ff;
   logic               bad_ff;

   logic               rsp_valid_ff;
   logic               rsp_wv_ff;
   logic [WORD_W-1:0]  rsp_word_ff;
   logic [STATE_W-1:0] rsp_sv_ff;
   logic               rsp_bad_ff;

   logic [STATE_W-1:0] cur_state;
   logic [FREQ_W-1:0]  cur_freq;
   logic [FREQ_W-1:0]  cur_cum;
   logic [PB_W-1:0]    pb_eff;
   logic [5:0]         limit_sh;
   logic [LIMIT_W-1:0] limit;
   logic               renorm;
   logic               enc_bad;
   logic [FREQ_W:0]    shifted;
   logic [FREQ_W+1:0]  diff;
   logic               ge;
   logic [STATE_W-1:0] new_state;
   logic               out_free;
   logic               rsp_wv_in;
   logic [WORD_W-1:0]  rsp_word_in;
   logic [STATE_W-1:0] rsp_sv_in;
   logic               rsp_bad_in;

   assign cur_state = lane_qv_ff ? lane_q_ff : LOWER_BOUND;
   assign cur_freq  = tab_qv_ff ? freq_q_ff : '0;
   assign cur_cum   = tab_qv_ff ? cum_q_ff : '0;
   assign pb_eff    = clamp_prob_bits(prob_bits_ff);
   assign limit_sh  = 6'd32 - {2'b00, pb_eff};
   assign limit     = LIMIT_W'(cur_freq) << limit_sh;
   assign renorm    = {6'b0, cur_state} >= limit;
   assign enc_bad   = (cur_freq == '0);

   assign shifted   = {rem_ff, quo_ff[STATE_W-1]};
   assign diff      = {1'b0, shifted} - {2'b00, cur_freq};
   assign ge        = !diff[FREQ_W+1];
   assign rem_in    = ge ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
   assign quo_in    = {quo_ff[STATE_W-2:0], ge};

   assign new_state = (quo_ff << pb_eff) + STATE_W'(cur_cum) + STATE_W'(rem_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      status          = '0;
      status.out_free = out_free;
      status.need_div = (kind_ff == KIND_ENCODE) && !enc_bad;
   end

   always_comb begin
      rsp_wv_in   = 1'b0;
      rsp_word_in = '0;
      rsp_sv_in   = '0;
      rsp_bad_in  = 1'b0;
      case (kind_ff)
         KIND_LOAD: begin
            rsp_sv_in = '0;
         end
         KIND_ENCODE: begin
            if (bad_ff) begin
               rsp_bad_in = 1'b1;
               rsp_sv_in  = cur_state;
            end else begin
               rsp_wv_in   = wv_ff;
               rsp_word_in = word_ff;
               rsp_sv_in   = new_state;
            end
         end
         KIND_READ: begin
            rsp_sv_in = cur_state;
         end
         KIND_RESET: begin
            rsp_sv_in = LOWER_BOUND;
         end
         default: begin
            rsp_sv_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prob_bits_ff <= PB_RESET;
      end else if (csr_write_enable) begin
         prob_bits_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= kind_type'(req_kind);
         lane_ff <= req_lane;
         sym_ff  <= req_symbol;
         freq_ff <= req_frequency;
         cum_ff  <= req_cumulative;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         lane_q_ff  <= lane_mem[lane_ff];
         lane_qv_ff <= lane_vld_ff[lane_ff];
         freq_q_ff  <= freq_mem[sym_ff];
         cum_q_ff   <= cum_mem[sym_ff];
         tab_qv_ff  <= tab_vld_ff[sym_ff];
      end
      if (cmd.finish && (kind_ff == KIND_ENCODE) && !bad_ff) begin
         lane_mem[lane_ff] <= new_state;
      end
      if (cmd.finish && (kind_ff == KIND_LOAD)) begin
         freq_mem[sym_ff] <= freq_ff;
         cum_mem[sym_ff]  <= cum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_vld_ff <= '0;
         tab_vld_ff  <= '0;
      end else if (cmd.finish) begin
         if ((kind_ff == KIND_ENCODE) && !bad_ff) begin
            lane_vld_ff[lane_ff] <= 1'b1;
         end
         if (kind_ff == KIND_RESET) begin
            lane_vld_ff <= '0;
         end
         if (kind_ff == KIND_LOAD) begin
            tab_vld_ff[sym_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         bad_ff  <= enc_bad;
         wv_ff   <= renorm;
         word_ff <= renorm ? cur_state[WORD_W-1:0] : '0;
         quo_ff  <= renorm ? (cur_state >> WORD_W) : cur_state;
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_wv_ff   <= rsp_wv_in;
         rsp_word_ff <= rsp_word_in;
         rsp_sv_ff   <= rsp_sv_in;
         rsp_bad_ff  <= rsp_bad_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word_valid  = rsp_wv_ff;
   assign rsp_out_word    = rsp_word_ff;
   assign rsp_state_value = rsp_sv_ff;
   assign rsp_bad_symbol  = rsp_bad_ff;

endmodule

// ----- sv/interleaved_rans_encoder_unit.sv -----
`timescale 1ns / 1ps
// Top level of the interleaved rANS encoder: joins the controller and datapath.
// Depends on rans_enc_pkg, rans_enc_ctrl and rans_enc_dp.
//
// Usage: each request transfer carries a kind, lane, symbol, frequency and
// cumulative value. Kind load writes one table entry, encode updates one lane
// state, read returns one lane state, and reset returns every lane to 65536.
// Every request produces exactly one response transfer on the rsp_ channel.
// The csr_ port writes prob_bits whenever csr_write_enable is high; it should
// only be written while no request is in flight.
// Encode of a symbol with nonzero frequency: the request is captured, the
// tables are read, the operands are evaluated, the radix-2 divider retires one
// quotient bit per cycle for every bit of the lane state, and the result is
// written back. Other kinds, and an encode of a zero-frequency symbol, skip
// the divider. One request is processed at a time, so a new request is taken
// only after the previous result enters the output register.
// Reset sets prob_bits to 15, all lanes to 65536 and all table entries to zero
// at once through valid bits; no clearing pass is needed.
// When the receiver stalls, the response register holds its value and the
// next finished result waits inside the block until the register frees up.
module interleaved_rans_encoder_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_kind,
   input  logic [rans_enc_pkg::LANE_W-1:0]  req_lane,
   input  logic [rans_enc_pkg::SYM_W-1:0]   req_symbol,
   input  logic [rans_enc_pkg::FREQ_W-1:0]  req_frequency,
   input  logic [rans_enc_pkg::FREQ_W-1:0]  req_cumulative,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_word_valid,
   output logic [rans_enc_pkg::WORD_W-1:0]  rsp_out_word,
   output logic [rans_enc_pkg::STATE_W-1:0] rsp_state_value,
   output logic                             rsp_bad_symbol,
   input  logic                             csr_write_enable,
   input  logic [rans_enc_pkg::PB_W-1:0]    csr_write_data
);
   import rans_enc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   rans_enc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rans_enc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_kind         (req_kind),
      .req_lane         (req_lane),
      .req_symbol       (req_symbol),
      .req_frequency    (req_frequency),
      .req_cumulative   (req_cumulative),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word_valid   (rsp_word_valid),
      .rsp_out_word     (rsp_out_word),
      .rsp_state_value  (rsp_state_value),
      .rsp_bad_symbol   (rsp_bad_symbol)
   );

endmodule

// ----- sv/rans_enc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker of the rANS encoder and its bind to the top level.
// Depends on rans_enc_pkg and interleaved_rans_encoder_unit.
module rans_enc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic                             rsp_word_valid,
   input logic [rans_enc_pkg::WORD_W-1:0]  rsp_out_word,
   input logic [rans_enc_pkg::STATE_W-1:0] rsp_state_value,
   input logic                             rsp_bad_symbol
);
   import rans_enc_pkg::*;

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a previous one is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_state_value)
                                    && $stable(rsp_out_word)))
      else $error("stalled response changed");

   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word_valid) |-> (rsp_out_word == '0))
      else $error("word nonzero without word valid");

   a_bad_no_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_symbol) |-> !rsp_word_valid)
      else $error("word emitted for a zero-frequency symbol");

endmodule

bind interleaved_rans_encoder_unit rans_enc_checker u_rans_enc_checker (.*);
